>>> rtl/assert_macros.svh
// concurrent assertion helpers, clocked on the rising edge and disabled in reset
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// next-cycle implication
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

>>> rtl/salc_pkg.sv
`default_nettype none

package salc_pkg;

   localparam int ADDR_W       = 64;
   localparam int OP_W         = 2;
   localparam int TOTAL_W      = 32;
   localparam int HIT_CNT_W    = 2;

   localparam int SET_BITS_W   = 3;
   localparam int BLOCK_BITS_W = 6;
   localparam int WAYS_USED_W  = 4;
   localparam int CSR_IDX_W    = 2;
   localparam int CSR_DATA_W   = 6;

   localparam logic [OP_W-1:0] OP_FETCH  = 2'd0;
   localparam logic [OP_W-1:0] OP_LOAD   = 2'd1;
   localparam logic [OP_W-1:0] OP_STORE  = 2'd2;
   localparam logic [OP_W-1:0] OP_MODIFY = 2'd3;

   localparam logic [CSR_IDX_W-1:0] CSR_SET_BITS   = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_BLOCK_BITS = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_WAYS_USED  = 2'd2;

   typedef struct packed {
      logic capture;
      logic commit;
   } salc_cmd_type;

   typedef struct packed {
      logic fetch;
   } salc_status_type;

endpackage

`default_nettype wire

>>> rtl/salc_ram.sv
`default_nettype none

module salc_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

>>> rtl/salc_ctrl.sv
`default_nettype none

module salc_ctrl (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_stall,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   input  salc_pkg::salc_status_type status,
   output salc_pkg::salc_cmd_type    cmd
);
   import salc_pkg::*;

   localparam logic ST_IDLE   = 1'b0;
   localparam logic ST_LOOKUP = 1'b1;

   logic state_ff, state_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic accept, can_commit;

   always_comb begin
      accept     = req_valid && (state_ff == ST_IDLE);
      // the output register is free, or its beat leaves this cycle
      can_commit = (state_ff == ST_LOOKUP) && (!rsp_valid_ff || !rsp_stall);

      cmd.capture = accept;
      cmd.commit  = can_commit;

      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept && !status.fetch) begin
               state_in = ST_LOOKUP;
            end
         end
         ST_LOOKUP: begin
            if (can_commit) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      rsp_valid_in = rsp_valid_ff;
      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
      if (can_commit) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

endmodule

`default_nettype wire

>>> rtl/salc_dpath.sv
`default_nettype none

module salc_dpath #(
   parameter int MAX_SET_BITS = 6,
   parameter int MAX_WAYS     = 8
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 csr_wr_en,
   input  logic [salc_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [salc_pkg::CSR_DATA_W-1:0]      csr_data,
   input  logic [salc_pkg::OP_W-1:0]            req_opcode,
   input  logic [salc_pkg::ADDR_W-1:0]          req_address,
   input  salc_pkg::salc_cmd_type               cmd,
   output salc_pkg::salc_status_type            status,
   output logic [salc_pkg::HIT_CNT_W-1:0]       rsp_hit_count,
   output logic                                 rsp_was_miss,
   output logic                                 rsp_was_eviction,
   output logic [salc_pkg::TOTAL_W-1:0]         rsp_total_hits,
   output logic [salc_pkg::TOTAL_W-1:0]         rsp_total_misses,
   output logic [salc_pkg::TOTAL_W-1:0]         rsp_total_evictions
);
   import salc_pkg::*;

   localparam int NUM_SETS = 1 << MAX_SET_BITS;
   localparam int SET_W    = (MAX_SET_BITS > 0) ? MAX_SET_BITS : 1;
   localparam int RANK_W   = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
   localparam int WAY_W    = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
   localparam int RANK_MAX = MAX_WAYS - 1;
   localparam int ROW_W    = MAX_WAYS * (1 + RANK_W + ADDR_W);

   // configuration
   logic [SET_BITS_W-1:0]   set_bits_ff;
   logic [BLOCK_BITS_W-1:0] block_bits_ff;
   logic [WAYS_USED_W-1:0]  ways_used_ff;

   logic [3:0]              sb_eff;
   logic [4:0]              ways_eff;
   logic [MAX_WAYS-1:0]     way_en;
   logic [SET_W-1:0]        idx_mask;
   logic [ADDR_W-1:0]       addr_shift;
   logic [SET_W-1:0]        set_idx;
   logic [6:0]              tag_amt;
   logic [ADDR_W-1:0]       tag_next;

   // access held between read and write back
   logic [ADDR_W-1:0]       tag_ff;
   logic [SET_W-1:0]        set_ff;
   logic                    modify_ff;

   logic [NUM_SETS-1:0]     row_ok_ff;
   logic                    row_ok;

   logic [ROW_W-1:0]                     rd_data;
   logic [MAX_WAYS-1:0]                  valid_q, valid_rd, valid_wr;
   logic [MAX_WAYS-1:0][RANK_W-1:0]      rank_q, rank_rd, rank_wr;
   logic [MAX_WAYS-1:0][ADDR_W-1:0]      tag_rd, tag_wr;

   logic                    hit, has_free, evict;
   logic [WAY_W-1:0]        hit_way, free_way, victim, touch_way;
   logic [RANK_W-1:0]       best, old_rank;
   logic [HIT_CNT_W-1:0]    hits;
   logic [TOTAL_W:0]        hit_sum, miss_sum, evict_sum;

   logic [TOTAL_W-1:0]      hit_total_ff, miss_total_ff, evict_total_ff;
   logic [HIT_CNT_W-1:0]    hit_count_ff;
   logic                    miss_ff, evict_ff;

   always_comb begin
      sb_eff = (int'(set_bits_ff) > MAX_SET_BITS) ? 4'(MAX_SET_BITS) : 4'(set_bits_ff);
      if (ways_used_ff == '0) begin
         ways_eff = 5'd1;
      end else if (int'(ways_used_ff) > MAX_WAYS) begin
         ways_eff = 5'(MAX_WAYS);
      end else begin
         ways_eff = 5'(ways_used_ff);
      end
      for (int i = 0; i < MAX_WAYS; i++) begin
         way_en[i] = (5'(i) < ways_eff);
      end
      for (int i = 0; i < SET_W; i++) begin
         idx_mask[i] = (4'(i) < sb_eff);
      end
      addr_shift = req_address >> block_bits_ff;
      set_idx    = addr_shift[SET_W-1:0] & idx_mask;
      // a shift of 64 or more leaves a zero tag
      tag_amt    = 7'(block_bits_ff) + 7'(sb_eff);
      tag_next   = req_address >> tag_amt;
   end

   assign status.fetch = (req_opcode == OP_FETCH);

   salc_ram #(
      .WIDTH (ROW_W),
      .DEPTH (NUM_SETS)
   ) u_row_ram (
      .clock   (clock),
      .wr_en   (cmd.commit),
      .wr_addr (set_ff),
      .wr_data ({valid_wr, rank_wr, tag_wr}),
      .rd_en   (cmd.capture),
      .rd_addr (set_idx),
      .rd_data (rd_data)
   );

   assign {valid_q, rank_q, tag_rd} = rd_data;

   always_comb begin
      // a set never written since reset reads as empty
      row_ok   = row_ok_ff[set_ff];
      valid_rd = row_ok ? valid_q : '0;
      rank_rd  = row_ok ? rank_q : '0;

      hit      = 1'b0;
      has_free = 1'b0;
      hit_way  = '0;
      free_way = '0;
      for (int i = MAX_WAYS - 1; i >= 0; i--) begin
         if (way_en[i] && valid_rd[i] && (tag_rd[i] == tag_ff)) begin
            hit     = 1'b1;
            hit_way = WAY_W'(i);
         end
         if (way_en[i] && !valid_rd[i]) begin
            has_free = 1'b1;
            free_way = WAY_W'(i);
         end
      end

      // oldest way, lowest index on a tie
      best   = rank_rd[0];
      victim = '0;
      for (int i = 1; i < MAX_WAYS; i++) begin
         if (way_en[i] && (rank_rd[i] > best)) begin
            best   = rank_rd[i];
            victim = WAY_W'(i);
         end
      end

      if (hit) begin
         touch_way = hit_way;
      end else if (has_free) begin
         touch_way = free_way;
      end else begin
         touch_way = victim;
      end
      old_rank = rank_rd[hit_way];
      evict    = !hit && !has_free;

      for (int i = 0; i < MAX_WAYS; i++) begin
         rank_wr[i] = rank_rd[i];
         if (WAY_W'(i) == touch_way) begin
            rank_wr[i] = '0;
         end else if (way_en[i] && valid_rd[i] && (!hit || (rank_rd[i] < old_rank))
                      && (rank_rd[i] < RANK_W'(RANK_MAX))) begin
            rank_wr[i] = rank_rd[i] + RANK_W'(1);
         end
      end

      valid_wr = valid_rd;
      tag_wr   = tag_rd;
      if (!hit) begin
         valid_wr[touch_way] = 1'b1;
         tag_wr[touch_way]   = tag_ff;
      end

      hits      = {1'b0, hit} + {1'b0, modify_ff};
      hit_sum   = {1'b0, hit_total_ff} + (TOTAL_W + 1)'(hits);
      miss_sum  = {1'b0, miss_total_ff} + (TOTAL_W + 1)'(!hit);
      evict_sum = {1'b0, evict_total_ff} + (TOTAL_W + 1)'(evict);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         set_bits_ff    <= '0;
         block_bits_ff  <= '0;
         ways_used_ff   <= WAYS_USED_W'(1);
         row_ok_ff      <= '0;
         hit_total_ff   <= '0;
         miss_total_ff  <= '0;
         evict_total_ff <= '0;
      end else begin
         if (csr_wr_en) begin
            case (csr_index)
               CSR_SET_BITS:   set_bits_ff   <= csr_data[SET_BITS_W-1:0];
               CSR_BLOCK_BITS: block_bits_ff <= csr_data[BLOCK_BITS_W-1:0];
               CSR_WAYS_USED:  ways_used_ff  <= csr_data[WAYS_USED_W-1:0];
               default: begin
               end
            endcase
         end
         if (cmd.commit) begin
            row_ok_ff[set_ff] <= 1'b1;
            // saturate at all ones
            hit_total_ff   <= hit_sum[TOTAL_W] ? '1 : hit_sum[TOTAL_W-1:0];
            miss_total_ff  <= miss_sum[TOTAL_W] ? '1 : miss_sum[TOTAL_W-1:0];
            evict_total_ff <= evict_sum[TOTAL_W] ? '1 : evict_sum[TOTAL_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         tag_ff    <= tag_next;
         set_ff    <= set_idx;
         modify_ff <= (req_opcode == OP_MODIFY);
      end
      if (cmd.commit) begin
         hit_count_ff <= hits;
         miss_ff      <= !hit;
         evict_ff     <= evict;
      end
   end

   // totals only move on commit, so they double as the output beat's totals
   assign rsp_hit_count       = hit_count_ff;
   assign rsp_was_miss        = miss_ff;
   assign rsp_was_eviction    = evict_ff;
   assign rsp_total_hits      = hit_total_ff;
   assign rsp_total_misses    = miss_total_ff;
   assign rsp_total_evictions = evict_total_ff;

endmodule

`default_nettype wire

>>> rtl/set_assoc_lru_cache_model.sv
// Tag-only set-associative cache with LRU replacement.
// Request channel (req_valid/req_stall): one access beat, an opcode and a
// 64-bit byte address. Response channel (rsp_valid/rsp_stall): one beat per
// load, store or modify with hit/miss/eviction flags and saturating totals.
// Instruction fetch beats are taken without leaving idle and produce no response.
// Timing: a counted access reads its set row from the row RAM at the edge
// it is accepted; in the lookup state it compares tags, picks the way and
// writes the row back once the response register can take the beat, and
// loads the response at that edge. No new access is taken before the row
// is written back. If the response register is still full and stalled, the
// lookup waits in place and the request side stays stalled; the
// response beat holds. The configuration (csr_wr_en/csr_index/csr_data)
// must be written by the user only while idle; the block does not enforce
// it. Reset (synchronous) empties every set at once, clears the totals and
// sets set_bits 0, block_bits 0, ways_used 1; no clearing pass is needed.
`default_nettype none
`include "assert_macros.svh"

module set_assoc_lru_cache_model #(
   parameter int MAX_SET_BITS = 6,
   parameter int MAX_WAYS     = 8
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_wr_en,
   input  logic [salc_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [salc_pkg::CSR_DATA_W-1:0]   csr_data,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic [salc_pkg::OP_W-1:0]         req_opcode,
   input  logic [salc_pkg::ADDR_W-1:0]       req_address,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic [salc_pkg::HIT_CNT_W-1:0]    rsp_hit_count,
   output logic                              rsp_was_miss,
   output logic                              rsp_was_eviction,
   output logic [salc_pkg::TOTAL_W-1:0]      rsp_total_hits,
   output logic [salc_pkg::TOTAL_W-1:0]      rsp_total_misses,
   output logic [salc_pkg::TOTAL_W-1:0]      rsp_total_evictions
);
   import salc_pkg::*;

   salc_cmd_type    cmd;
   salc_status_type status;
   logic            access_beat;

   salc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .status    (status),
      .cmd       (cmd)
   );

   salc_dpath #(
      .MAX_SET_BITS (MAX_SET_BITS),
      .MAX_WAYS     (MAX_WAYS)
   ) u_dpath (
      .clock               (clock),
      .reset               (reset),
      .csr_wr_en           (csr_wr_en),
      .csr_index           (csr_index),
      .csr_data            (csr_data),
      .req_opcode          (req_opcode),
      .req_address         (req_address),
      .cmd                 (cmd),
      .status              (status),
      .rsp_hit_count       (rsp_hit_count),
      .rsp_was_miss        (rsp_was_miss),
      .rsp_was_eviction    (rsp_was_eviction),
      .rsp_total_hits      (rsp_total_hits),
      .rsp_total_misses    (rsp_total_misses),
      .rsp_total_evictions (rsp_total_evictions)
   );

   // a load, store or modify beat taken this cycle
   assign access_beat = req_valid && !req_stall && (req_opcode != OP_FETCH);

   `ASSERT_NEXT(a_busy_after_access, clock, reset, access_beat, req_stall)
   `ASSERT_NEXT(a_commit_gives_beat, clock, reset, cmd.commit, rsp_valid)
   `ASSERT_NEXT(a_commit_frees_req, clock, reset, cmd.commit, !req_stall)
   `ASSERT_IMPLY(a_evict_is_miss, clock, reset, rsp_valid, !rsp_was_eviction || rsp_was_miss)

endmodule

`default_nettype wire
